FILE: src/rldf_pkg.sv
// Shared types and constants for the run-length delta frame decoder.
// Used by the front end, the back end and the top level; depends on nothing.
package rldf_pkg;

   // Request action codes.
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_STREAM = 2'd1;
   localparam logic [1:0] ACT_START  = 2'd2;

   // Header byte layout: top bit picks literal mode, low bits give the count.
   localparam int         HDR_MODE_BIT = 7;
   localparam logic [7:0] HDR_COUNT_MASK = 8'b0111_1111;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LITERAL,
      PH_RUN
   } phase_type;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_START,
      CMD_RUN
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_EMIT
   } back_state_type;

   // Work item passed from the front end to the back end.
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   byte_value;
      logic [9:0]   load_index;
      logic [6:0]   count;
   } cmd_type;

   typedef struct packed {
      logic [9:0] position;
      logic [7:0] pixel_first;
      logic [7:0] pixel_second;
      logic       second_valid;
      logic       beyond_base;
      logic       last;
   } result_type;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RES_W = $bits(result_type);

endpackage

FILE: src/rldf_fifo.sv
// Small synchronous queue used between the decoder stages and at the result side.
// Depends on nothing; DEPTH must be a power of two, two or more.
module rldf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: src/rldf_front.sv
// Front end: accepts request items, tracks the header/literal/run phase and
// turns loads, starts, literals and non-empty runs into back-end commands. Depends on rldf_pkg.
module rldf_front
   import rldf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [1:0] req_action,
   input  logic [7:0] req_byte_value,
   input  logic [9:0] req_load_index,
   output logic       req_full,
   output logic       cmd_push,
   output cmd_type    cmd,
   input  logic       cmd_full
);
   phase_type  phase_ff, phase_in;
   logic [6:0] remaining_ff, remaining_in;
   logic [6:0] hdr_count;
   logic [6:0] lit_left;
   logic       accept;

   assign req_full  = cmd_full;
   assign accept    = req_push && !cmd_full;
   assign hdr_count = 7'(req_byte_value & HDR_COUNT_MASK);
   assign lit_left  = remaining_ff - 7'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         remaining_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      remaining_in     = remaining_ff;
      cmd_push         = 1'b0;
      cmd.kind         = CMD_RUN;
      cmd.byte_value   = req_byte_value;
      cmd.load_index   = req_load_index;
      cmd.count        = 7'd1;
      if (accept) begin
         unique case (req_action)
            ACT_LOAD: begin
               cmd_push = 1'b1;
               cmd.kind = CMD_LOAD;
            end
            ACT_START: begin
               cmd_push     = 1'b1;
               cmd.kind     = CMD_START;
               phase_in     = PH_HEADER;
               remaining_in = '0;
            end
            ACT_STREAM: begin
               unique case (phase_ff)
                  PH_HEADER: begin
                     remaining_in = hdr_count;
                     if (req_byte_value[HDR_MODE_BIT]) begin
                        phase_in = (hdr_count != '0) ? PH_LITERAL : PH_HEADER;
                     end else begin
                        phase_in = PH_RUN;
                     end
                  end
                  PH_LITERAL: begin
                     // a literal is a run of one pixel
                     cmd_push     = 1'b1;
                     remaining_in = lit_left;
                     if (lit_left == '0) begin
                        phase_in = PH_HEADER;
                     end
                  end
                  PH_RUN: begin
                     // drop an empty run: it consumes the value byte only
                     cmd_push     = (remaining_ff != '0);
                     cmd.count    = remaining_ff;
                     remaining_in = '0;
                     phase_in     = PH_HEADER;
                  end
                  default: begin
                     phase_in = PH_HEADER;
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

endmodule

FILE: src/rldf_back.sv
// Back end: executes commands against the base frame memory and builds
// paired-pixel results. Depends on rldf_pkg.
module rldf_back
   import rldf_pkg::*;
#(
   parameter int BASE_BYTES = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic       cmd_empty,
   output logic       cmd_pop,
   output result_type res,
   output logic       res_push,
   input  logic       res_full
);
   localparam int AW = $clog2(BASE_BYTES);
   localparam int PW = $clog2(BASE_BYTES + 1);
   localparam logic [PW-1:0] POS_END = PW'(BASE_BYTES);

   logic [7:0]     base_mem [BASE_BYTES];
   back_state_type state_ff, state_in;
   logic [PW-1:0]  pos_ff, pos_in;
   logic [6:0]     cnt_ff, cnt_in;
   logic [7:0]     data_ff, data_in;
   logic [7:0]     rd_a_ff, rd_b_ff;

   logic           mem_wr, mem_rd;
   logic [AW-1:0]  wr_addr, addr_a, addr_b;
   logic           idx_ok;
   logic           a_in, b_in, second;
   logic [PW-1:0]  pos_q, pos_after;
   logic [6:0]     cnt_left;

   assign idx_ok  = (32'(cmd.load_index) < 32'(BASE_BYTES));
   assign wr_addr = AW'(cmd.load_index);

   // Position of each pixel of the pair; it sticks at the end of the store.
   assign a_in      = (pos_ff < POS_END);
   assign pos_q     = a_in ? pos_ff + PW'(1) : pos_ff;
   assign b_in      = (pos_q < POS_END);
   assign second    = (cnt_ff > 7'd1);
   assign pos_after = second ? (b_in ? pos_q + PW'(1) : pos_q) : pos_q;
   assign cnt_left  = cnt_ff - (second ? 7'd2 : 7'd1);
   assign addr_a    = a_in ? AW'(pos_ff) : '0;
   assign addr_b    = b_in ? AW'(pos_q) : '0;

   always_comb begin
      res.position     = 10'(pos_ff);
      res.pixel_first  = a_in ? rd_a_ff - data_ff : 8'd0;
      res.pixel_second = (second && b_in) ? rd_b_ff - data_ff : 8'd0;
      res.second_valid = second;
      res.beyond_base  = !a_in || (second && !b_in);
      res.last         = (cnt_left == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         pos_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         base_mem[wr_addr] <= cmd.byte_value;
      end
      if (mem_rd) begin
         rd_a_ff <= base_mem[addr_a];
         rd_b_ff <= base_mem[addr_b];
      end
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      data_in  = data_ff;
      cmd_pop  = 1'b0;
      mem_wr   = 1'b0;
      mem_rd   = 1'b0;
      res_push = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  CMD_LOAD: begin
                     mem_wr = idx_ok;
                  end
                  CMD_START: begin
                     pos_in = '0;
                  end
                  CMD_RUN: begin
                     cnt_in   = cmd.count;
                     data_in  = cmd.byte_value;
                     state_in = BK_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_READ: begin
            mem_rd   = 1'b1;
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            // hold the pair until the result queue has room
            if (!res_full) begin
               res_push = 1'b1;
               pos_in   = pos_after;
               cnt_in   = cnt_left;
               state_in = (cnt_left == '0) ? BK_IDLE : BK_READ;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   a_emit_has_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_EMIT |-> cnt_ff != '0)
      else $error("emit state with no pixels left");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_END)
      else $error("output position ran past the store end");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      res_push && res.last |=> state_ff == BK_IDLE)
      else $error("back end kept working after the last result");

   a_read_then_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_READ |=> state_ff == BK_EMIT)
      else $error("memory read not followed by emit");

endmodule

FILE: src/rle_delta_frame_decoder.sv
// Top level of the run-length delta frame decoder: front end, command queue,
// back end with base frame memory, result queue. Depends on rldf_pkg and submodules.
//
//   channel   direction  handshake          payload
//   req_*     in         req_push/req_full  action, byte_value, load_index
//   rsp_*     out        rsp_pop/rsp_empty  position, pixel pair, flags
//
// Header bytes are absorbed by the front end and make no command. The back end pops
// each command in its idle state; for a run, each pixel pair then takes a memory read
// state and then an emit state, since the memory read is registered.
// Reset clears the decode phase, counters, output position and both queues; the
// base memory is not cleared. A full result queue holds the back end, and a full
// command queue raises req_full.
module rle_delta_frame_decoder
   import rldf_pkg::*;
#(
   parameter int BASE_BYTES = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [1:0] req_action,
   input  logic [7:0] req_byte_value,
   input  logic [9:0] req_load_index,
   output logic       req_full,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [9:0] rsp_position,
   output logic [7:0] rsp_pixel_first,
   output logic [7:0] rsp_pixel_second,
   output logic       rsp_second_valid,
   output logic       rsp_beyond_base,
   output logic       rsp_last
);
   cmd_type          front_cmd, back_cmd;
   logic [CMD_W-1:0] front_cmd_vec, back_cmd_vec;
   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   result_type       back_res, head_res;
   logic [RES_W-1:0] back_res_vec, head_res_vec;
   logic             res_push, res_full;

   assign front_cmd_vec = front_cmd;
   assign back_cmd      = cmd_type'(back_cmd_vec);
   assign back_res_vec  = back_res;
   assign head_res      = result_type'(head_res_vec);

   rldf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_action     (req_action),
      .req_byte_value (req_byte_value),
      .req_load_index (req_load_index),
      .req_full       (req_full),
      .cmd_push       (cmd_push),
      .cmd            (front_cmd),
      .cmd_full       (cmd_full)
   );

   rldf_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (4)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (front_cmd_vec),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (back_cmd_vec),
      .empty   (cmd_empty)
   );

   rldf_back #(
      .BASE_BYTES (BASE_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .res       (back_res),
      .res_push  (res_push),
      .res_full  (res_full)
   );

   rldf_fifo #(
      .WIDTH (RES_W),
      .DEPTH (2)
   ) u_res_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (back_res_vec),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (head_res_vec),
      .empty   (rsp_empty)
   );

   assign rsp_position     = head_res.position;
   assign rsp_pixel_first  = head_res.pixel_first;
   assign rsp_pixel_second = head_res.pixel_second;
   assign rsp_second_valid = head_res.second_valid;
   assign rsp_beyond_base  = head_res.beyond_base;
   assign rsp_last         = head_res.last;

endmodule

FILE: verif/tb_top.sv
// Testbench for rle_delta_frame_decoder: loads the base frame, drives compressed streams
// and checks every pixel pair against a built-in decoder model, with random idling.
// Depends on rldf_pkg and the rle_delta_frame_decoder RTL.
module tb_top
   import rldf_pkg::*;
();

   localparam int          BASE_BYTES   = 1024;
   localparam logic [10:0] POS_END      = 11'(BASE_BYTES);
   localparam logic [1:0]  ACT_UNUSED   = 2'd3;
   localparam int          CYCLE_LIMIT  = 400_000;
   localparam int          DRAIN_CYCLES = 300;
   localparam int          REPORT_MAX   = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic [1:0] req_action = ACT_UNUSED;
   logic [7:0] req_byte_value = 8'h00;
   logic [9:0] req_load_index = 10'h000;
   logic       req_full;
   logic       rsp_pop = 1'b0;
   logic       rsp_empty;
   logic [9:0] rsp_position;
   logic [7:0] rsp_pixel_first;
   logic [7:0] rsp_pixel_second;
   logic       rsp_second_valid;
   logic       rsp_beyond_base;
   logic       rsp_last;

   // decoder model state
   logic [7:0]  frame_copy [BASE_BYTES];
   logic [10:0] write_pos = '0;
   phase_type   parse_phase = PH_HEADER;
   logic [6:0]  bytes_left = '0;

   result_type  pending_pixels [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned rsp_hold_request = 0;
   logic        send_idle = 1'b0;
   logic        recv_idle = 1'b0;

   rle_delta_frame_decoder #(
      .BASE_BYTES(BASE_BYTES)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_action      (req_action),
      .req_byte_value  (req_byte_value),
      .req_load_index  (req_load_index),
      .req_full        (req_full),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_position    (rsp_position),
      .rsp_pixel_first (rsp_pixel_first),
      .rsp_pixel_second(rsp_pixel_second),
      .rsp_second_valid(rsp_second_valid),
      .rsp_beyond_base (rsp_beyond_base),
      .rsp_last        (rsp_last)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [7:0] delta_pixel(input logic [10:0] pos, input logic [7:0] data);
      if (pos >= POS_END)
         return 8'h00;
      return frame_copy[pos[9:0]] - data;
   endfunction

   function automatic void advance_pos();
      if (write_pos < POS_END)
         write_pos++;
   endfunction

   // Work out the pixel pairs one accepted item produces.
   function automatic void decode_item(input logic [1:0] action, input logic [7:0] data,
                                       input logic [9:0] index);
      result_type pair;
      int         cnt;
      case (action)
         ACT_LOAD: begin
            frame_copy[index] = data;
         end
         ACT_START: begin
            write_pos   = '0;
            parse_phase = PH_HEADER;
            bytes_left  = '0;
         end
         ACT_STREAM: begin
            case (parse_phase)
               PH_LITERAL: begin
                  pair.position     = write_pos[9:0];
                  pair.pixel_first  = delta_pixel(write_pos, data);
                  pair.pixel_second = 8'h00;
                  pair.second_valid = 1'b0;
                  pair.beyond_base  = write_pos >= POS_END;
                  pair.last         = 1'b1;
                  pending_pixels.push_back(pair);
                  advance_pos();
                  bytes_left--;
                  if (bytes_left == '0)
                     parse_phase = PH_HEADER;
               end
               PH_RUN: begin
                  cnt = int'(bytes_left);
                  while (cnt > 0) begin
                     pair.position     = write_pos[9:0];
                     pair.pixel_first  = delta_pixel(write_pos, data);
                     pair.pixel_second = 8'h00;
                     pair.second_valid = 1'b0;
                     pair.beyond_base  = write_pos >= POS_END;
                     advance_pos();
                     cnt--;
                     if (cnt > 0) begin
                        pair.pixel_second = delta_pixel(write_pos, data);
                        pair.second_valid = 1'b1;
                        if (write_pos >= POS_END)
                           pair.beyond_base = 1'b1;
                        advance_pos();
                        cnt--;
                     end
                     pair.last = (cnt == 0);
                     pending_pixels.push_back(pair);
                  end
                  bytes_left  = '0;
                  parse_phase = PH_HEADER;
               end
               default: begin
                  bytes_left = 7'(data & HDR_COUNT_MASK);
                  if (data[HDR_MODE_BIT])
                     parse_phase = (bytes_left != '0) ? PH_LITERAL : PH_HEADER;
                  else
                     parse_phase = PH_RUN;
               end
            endcase
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_item(input logic [1:0] action, input logic [7:0] data,
                            input logic [9:0] index);
      int unsigned gap;
      gap = (send_idle && $urandom_range(0, 1)) ? $urandom_range(0, 14) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push       <= 1'b1;
      req_action     <= action;
      req_byte_value <= data;
      req_load_index <= index;
      do
         @(posedge clock);
      while (req_full);
      decode_item(action, data, index);
      items_sent++;
   endtask

   // Drop push so the last item is not taken twice while the test waits.
   task automatic stop_requests();
      @(negedge clock);
      req_push <= 1'b0;
   endtask

   task automatic note_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("cycle %0d: %s", cycle_count, what);
   endtask

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v)
         note_failure($sformatf("%s mismatch: expected %0d, got %0d", name, exp_v, act_v));
   endtask

   always @(posedge clock) begin : result_check
      result_type exp_pair;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_pixels.size() == 0) begin
            note_failure($sformatf("unexpected item at position %0d", rsp_position));
         end else begin
            exp_pair = pending_pixels.pop_front();
            check_field("position", exp_pair.position, rsp_position);
            check_field("pixel_first", exp_pair.pixel_first, rsp_pixel_first);
            check_field("pixel_second", exp_pair.pixel_second, rsp_pixel_second);
            check_field("second_valid", exp_pair.second_valid, rsp_second_valid);
            check_field("beyond_base", exp_pair.beyond_base, rsp_beyond_base);
            check_field("last", exp_pair.last, rsp_last);
         end
      end
   end

   initial begin : result_sink
      int unsigned gap;
      wait (!reset);
      forever begin
         if (rsp_hold_request != 0) begin
            gap = rsp_hold_request;
            rsp_hold_request = 0;
         end else begin
            gap = (recv_idle && $urandom_range(0, 1)) ? $urandom_range(0, 14) : 0;
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_pop <= 1'b0;
         end
         @(negedge clock);
         rsp_pop <= 1'b1;
         do
            @(posedge clock);
         while (rsp_empty);
      end
   end

   // Write every base entry so no later position reads an unloaded byte.
   task automatic test_base_load();
      logic [7:0] value;
      send_idle = 1'b1;
      for (int i = 0; i < BASE_BYTES; i++) begin
         if (i == 64)
            send_idle = 1'b0;
         if (i == 0)
            value = 8'h00;
         else if (i == BASE_BYTES - 1)
            value = 8'hFF;
         else
            value = 8'($urandom);
         send_item(ACT_LOAD, value, 10'(i));
      end
      stop_requests();
   endtask

   task automatic test_special_cases();
      send_idle = 1'b1;
      recv_idle = 1'b1;
      send_item(ACT_START, 8'h00, 10'h000);
      send_item(ACT_STREAM, 8'h80, 10'h000);        // literal with zero count
      send_item(ACT_STREAM, 8'h00, 10'h000);        // run with zero count
      send_item(ACT_STREAM, 8'h37, 10'h3FF);        // run value, no pixels
      send_item(ACT_STREAM, 8'h83, 10'h000);
      send_item(ACT_STREAM, 8'h00, 10'h000);
      send_item(ACT_STREAM, 8'hFF, 10'h000);
      send_item(ACT_STREAM, 8'h5A, 10'h000);
      send_item(ACT_UNUSED, 8'hFF, 10'h3FF);
      send_item(ACT_STREAM, 8'h7F, 10'h000);        // longest run, odd tail
      send_item(ACT_STREAM, 8'hFF, 10'h000);
      send_item(ACT_STREAM, 8'h02, 10'h000);
      send_item(ACT_STREAM, 8'h00, 10'h000);
      send_item(ACT_STREAM, 8'h01, 10'h000);        // single-pixel run
      send_item(ACT_STREAM, 8'h80, 10'h000);
      send_item(ACT_LOAD, 8'hFF, 10'h3FF);
      send_item(ACT_LOAD, 8'h00, 10'h000);
      send_item(ACT_START, 8'hFF, 10'h3FF);
      send_item(ACT_STREAM, 8'h81, 10'h000);
      send_item(ACT_STREAM, 8'hFF, 10'h000);
      stop_requests();
   endtask

   // Walk past the end of the base store; one pair straddles the boundary.
   task automatic test_past_store();
      send_idle = 1'b0;
      recv_idle = 1'b1;
      send_item(ACT_START, 8'h00, 10'h000);
      send_item(ACT_STREAM, 8'h81, 10'h000);
      send_item(ACT_STREAM, 8'($urandom), 10'h000);
      repeat (9) begin
         send_item(ACT_STREAM, 8'h7F, 10'h000);
         send_item(ACT_STREAM, 8'($urandom), 10'h000);
      end
      send_item(ACT_STREAM, 8'h82, 10'h000);
      send_item(ACT_STREAM, 8'($urandom), 10'h000);
      send_item(ACT_STREAM, 8'($urandom), 10'h000);
      stop_requests();
   endtask

   task automatic test_random_stream();
      int unsigned first;
      int unsigned pick;
      int unsigned n;
      first = items_sent;
      send_item(ACT_START, 8'($urandom), 10'($urandom));
      while (items_sent - first < 100) begin
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 19);
         if (pick < 8) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 9);
            send_item(ACT_STREAM, {1'b0, 7'(n)}, 10'($urandom));
            send_item(ACT_STREAM, 8'($urandom), 10'($urandom));
         end else if (pick < 14) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 6);
            send_item(ACT_STREAM, {1'b1, 7'(n)}, 10'($urandom));
            repeat (n) send_item(ACT_STREAM, 8'($urandom), 10'($urandom));
         end else if (pick < 16) begin
            // cut a literal short and restart the frame
            n = $urandom_range(3, 8);
            send_item(ACT_STREAM, {1'b1, 7'(n)}, 10'($urandom));
            repeat ($urandom_range(0, n - 1)) send_item(ACT_STREAM, 8'($urandom), 10'($urandom));
            send_item(ACT_START, 8'($urandom), 10'($urandom));
         end else if (pick == 16) begin
            send_item(ACT_START, 8'($urandom), 10'($urandom));
         end else if (pick == 17) begin
            send_item(ACT_LOAD, 8'($urandom), 10'($urandom));
         end else if (pick == 18) begin
            send_item(ACT_UNUSED, 8'($urandom), 10'($urandom));
         end else begin
            send_item(ACT_STREAM, 8'($urandom), 10'($urandom));
         end
      end
      stop_requests();
   endtask

   // Hold the result side while long runs keep coming, so both queues fill.
   task automatic test_backpressure();
      send_idle = 1'b0;
      recv_idle = 1'b1;
      rsp_hold_request = 800;
      send_item(ACT_START, 8'h00, 10'h000);
      repeat (10) begin
         send_item(ACT_STREAM, 8'h7F, 10'h000);
         send_item(ACT_STREAM, 8'($urandom), 10'h000);
      end
      stop_requests();
   endtask

   initial begin : main_sequence
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_base_load();
      test_special_cases();
      test_past_store();
      test_random_stream();
      test_backpressure();
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
